// File: rtl/lfps_pkg.sv
package lfps_pkg;

  // Sensor word and field widths
  localparam int unsigned SENSOR_W    = 16;
  localparam int unsigned SENSED_BITS = 15;
  localparam int unsigned SEL_W       = $clog2(SENSOR_W);
  localparam int unsigned OFFSET_W    = 6;
  localparam int unsigned CMD_W       = 16;
  localparam int unsigned GAIN_W      = 16;

  // Stop grouping
  localparam int unsigned STOP_GROUP = 4;
  localparam int unsigned GRP_W      = (STOP_GROUP > 2) ? $clog2(STOP_GROUP) : 1;

  // Decoupling queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // PID datapath widths
  localparam int unsigned DIFF1_W = OFFSET_W + 1;
  localparam int unsigned DIFF2_W = OFFSET_W + 2;
  localparam int unsigned PROD_W  = GAIN_W + DIFF2_W;
  localparam int unsigned DELTA_W = PROD_W + 2;
  localparam int unsigned ACC_W   = 40;

  // Turn scaling: t = (|acc| * 2621) >> 16, clamped to 1.0 in Q2.14
  localparam int unsigned MAG_W      = 20;
  localparam int unsigned SCALE_W    = 12;
  localparam int unsigned SCALED_W   = MAG_W + SCALE_W;
  localparam int unsigned TURN_SHIFT = 16;
  localparam logic [SCALE_W-1:0] TURN_SCALE = SCALE_W'(2621);
  localparam logic [CMD_W-1:0]   TURN_LIMIT = CMD_W'(16384);

  // Offset reported when no sensed bit is set
  localparam logic signed [OFFSET_W-1:0] OFFSET_LOST = OFFSET_W'(16);
  localparam logic signed [OFFSET_W-1:0] OFFSET_BIAS = OFFSET_W'(12);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP     = 2'd0,
    CFG_GAIN_INTEG    = 2'd1,
    CFG_GAIN_DERIV    = 2'd2,
    CFG_FORWARD_SPEED = 2'd3
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST     = 16'sd4096;
  localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST    = 16'sd410;
  localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST    = 16'sd819;
  localparam logic signed [CMD_W-1:0]  FORWARD_SPEED_RST = -16'sd1638;

  // Live configuration as seen by the back end
  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic signed [CMD_W-1:0]  speed;
  } cfg_t;

  // One classified sample travelling through the queue
  typedef struct packed {
    logic signed [OFFSET_W-1:0] offset;
    logic                       stop;
    logic                       emit;
  } item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: rtl/lfps_front.sv
module lfps_front import lfps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SENSOR_W-1:0] sensor_bits_i,
  input  qstat_t              qstat_i,
  output logic                push_o,
  output item_t               item_o
);

  logic [GRP_W-1:0] grp_pos_q, grp_pos_d;
  logic             all_zero_q, all_zero_d;
  logic             stopped_q, stopped_d;

  logic [SEL_W-1:0] low_bit;
  logic             found;
  logic             three_set;
  logic             zero_now;
  logic             closes;
  logic             stop_now;
  logic signed [OFFSET_W-1:0] offset;

  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i & ~qstat_i.full;

  // Lowest set bit among the sensed bits
  always_comb begin
    low_bit = '0;
    found   = 1'b0;
    for (int k = SENSED_BITS - 1; k >= 0; k--) begin
      if (sensor_bits_i[k]) begin
        low_bit = SEL_W'(k);
        found   = 1'b1;
      end
    end
  end

  assign three_set = ($countones(sensor_bits_i) == 3);

  // (k-6)*2 is even, so the three-bit bump is just bit 0
  always_comb begin
    if (found) begin
      offset    = $signed({1'b0, low_bit, 1'b0}) - OFFSET_BIAS;
      offset[0] = three_set;
    end else begin
      offset = OFFSET_LOST;
    end
  end

  // Group tracking and stop decision
  assign zero_now = all_zero_q & (sensor_bits_i == '0);
  assign closes   = (grp_pos_q == GRP_W'(STOP_GROUP - 1));
  assign stop_now = closes & zero_now;

  always_comb begin
    grp_pos_d  = grp_pos_q;
    all_zero_d = all_zero_q;
    stopped_d  = stopped_q;
    if (push_o) begin
      grp_pos_d  = closes ? '0 : grp_pos_q + 1'b1;
      all_zero_d = closes ? 1'b1 : zero_now;
      stopped_d  = stopped_q | stop_now;
    end
  end

  assign item_o.offset = offset;
  assign item_o.stop   = stop_now;
  assign item_o.emit   = stop_now | ~stopped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_pos_q  <= '0;
      all_zero_q <= 1'b1;
      stopped_q  <= 1'b0;
    end else begin
      grp_pos_q  <= grp_pos_d;
      all_zero_q <= all_zero_d;
      stopped_q  <= stopped_d;
    end
  end

endmodule

// File: rtl/lfps_queue.sv
module lfps_queue import lfps_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  head_o,
  output qstat_t qstat_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign qstat_o.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign head_o        = mem_q[rd_ptr_q];

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/lfps_back.sv
module lfps_back import lfps_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  qstat_t                     qstat_i,
  input  item_t                      head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [CMD_W-1:0]    speed_cmd_o,
  output logic signed [CMD_W-1:0]    turn_cmd_o,
  output logic signed [OFFSET_W-1:0] line_offset_o,
  output logic                       stop_flag_o
);

  logic en;

  // Error history
  logic signed [OFFSET_W-1:0] err1_q, err2_q;

  // Stage A: PID delta
  logic                       va_q;
  item_t                      ia_q;
  logic signed [DELTA_W-1:0]  delta_q;
  logic signed [DIFF1_W-1:0]  diff1;
  logic signed [DIFF2_W-1:0]  diff2;
  logic signed [PROD_W-1:0]   prod_p, prod_i, prod_d;
  logic signed [DELTA_W-1:0]  delta;

  // Stage B: accumulator
  logic                       vb_q;
  item_t                      ib_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [ACC_W:0]      acc_sum;
  logic                       gains_zero;

  // Stage C: turn scaling
  logic [ACC_W-1:0]           mag;
  logic                       mag_big;
  logic [MAG_W-1:0]           mag_cut;
  logic [SCALED_W-1:0]        scaled;
  logic [CMD_W-1:0]           turn_abs;
  logic signed [CMD_W-1:0]    turn;

  logic                       out_valid_q;
  logic signed [CMD_W-1:0]    speed_q, turn_q;
  logic signed [OFFSET_W-1:0] offset_q;
  logic                       stop_q;

  // Whole pipeline advances unless a result is held by the receiver
  assign en    = ~out_valid_q | ~out_stall_i;
  assign pop_o = en & ~qstat_i.empty;

  // Incremental PID delta from the head of the queue
  always_comb begin
    diff1  = DIFF1_W'(head_i.offset) - DIFF1_W'(err1_q);
    diff2  = DIFF2_W'(head_i.offset) - (DIFF2_W'(err1_q) <<< 1) + DIFF2_W'(err2_q);
    prod_p = cfg_i.kp * PROD_W'(diff1);
    prod_i = cfg_i.ki * PROD_W'(head_i.offset);
    prod_d = cfg_i.kd * PROD_W'(diff2);
    delta  = DELTA_W'(prod_p) + DELTA_W'(prod_i) + DELTA_W'(prod_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      err1_q <= '0;
      err2_q <= '0;
    end else if (en) begin
      va_q <= pop_o;
      if (pop_o) begin
        err1_q <= head_i.offset;
        err2_q <= err1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ia_q    <= head_i;
      delta_q <= delta;
    end
  end

  // Saturating accumulate, cleared while all gains are zero
  assign gains_zero = (cfg_i.kp == '0) & (cfg_i.ki == '0) & (cfg_i.kd == '0);
  assign acc_sum    = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(delta_q);

  always_comb begin
    if (gains_zero) begin
      acc_d = '0;
    end else if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_d = acc_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      acc_d = acc_sum[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q  <= 1'b0;
      acc_q <= '0;
    end else if (en) begin
      vb_q <= va_q;
      if (va_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && va_q) begin
      ib_q <= ia_q;
    end
  end

  // Turn magnitude; anything at or above 2^20 is past the clamp anyway
  always_comb begin
    mag      = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    mag_big  = |mag[ACC_W-1:MAG_W];
    mag_cut  = mag_big ? {MAG_W{1'b1}} : mag[MAG_W-1:0];
    scaled   = SCALED_W'(mag_cut) * SCALED_W'(TURN_SCALE);
    turn_abs = scaled[SCALED_W-1:TURN_SHIFT];
    if (mag_big || (turn_abs > TURN_LIMIT)) begin
      turn_abs = TURN_LIMIT;
    end
    turn = (ib_q.offset <= 0) ? $signed(turn_abs) : -$signed(turn_abs);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vb_q & ib_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vb_q) begin
      speed_q  <= ib_q.stop ? '0 : cfg_i.speed;
      turn_q   <= ib_q.stop ? '0 : turn;
      offset_q <= ib_q.offset;
      stop_q   <= ib_q.stop;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign speed_cmd_o   = speed_q;
  assign turn_cmd_o    = turn_q;
  assign line_offset_o = offset_q;
  assign stop_flag_o   = stop_q;

endmodule

// File: rtl/line_follow_pid_steering_unit.sv
// Line-following steering unit.
// Input channel: one 16-bit line-sensor word per beat (in_valid_i / in_stall_o).
// Output channel: one steering command per beat (out_valid_o / out_stall_i):
// forward speed, turn rate, the lateral offset found and a stop flag.
// Gains and forward speed are written through cfg_we_i / cfg_idx_i / cfg_data_i
// while the unit is idle; writes take effect on the next sample.
// Throughput is one sample per cycle while the receiver does not stall. From the
// accepted input beat to the output beat a sample passes the queue, the PID delta
// stage, the accumulator stage, then the turn scaling into the output register.
// A 4-entry queue separates the classifying front end from the PID back end;
// in_stall_o rises only when that queue is full.
// After a stop is latched, samples still update the PID but produce no beat,
// except the zero stop commands that close all-zero groups.
// When the receiver stalls, the output beat holds and the back end freezes;
// the front end keeps accepting until the queue fills.
// Reset clears the PID history, the accumulator, the group state and the stop
// latch, and loads the default gains and speed. No clearing pass is needed.
module line_follow_pid_steering_unit import lfps_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CMD_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [SENSOR_W-1:0]        sensor_bits_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [CMD_W-1:0]    speed_cmd_o,
  output logic signed [CMD_W-1:0]    turn_cmd_o,
  output logic signed [OFFSET_W-1:0] line_offset_o,
  output logic                       stop_flag_o
);

  cfg_t   cfg_q;
  qstat_t qstat;
  item_t  push_item, head_item;
  logic   push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp    <= GAIN_PROP_RST;
      cfg_q.ki    <= GAIN_INTEG_RST;
      cfg_q.kd    <= GAIN_DERIV_RST;
      cfg_q.speed <= FORWARD_SPEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_PROP:     cfg_q.kp    <= cfg_data_i;
        CFG_GAIN_INTEG:    cfg_q.ki    <= cfg_data_i;
        CFG_GAIN_DERIV:    cfg_q.kd    <= cfg_data_i;
        CFG_FORWARD_SPEED: cfg_q.speed <= cfg_data_i;
        default:           cfg_q       <= cfg_q;
      endcase
    end
  end

  lfps_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sensor_bits_i (sensor_bits_i),
    .qstat_i       (qstat),
    .push_o        (push),
    .item_o        (push_item)
  );

  lfps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .qstat_o (qstat)
  );

  lfps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .qstat_i       (qstat),
    .head_i        (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .speed_cmd_o   (speed_cmd_o),
    .turn_cmd_o    (turn_cmd_o),
    .line_offset_o (line_offset_o),
    .stop_flag_o   (stop_flag_o)
  );

  // A stop beat carries zero speed and zero turn
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stop_flag_o) |-> (speed_cmd_o == '0 && turn_cmd_o == '0))
    else $error("stop beat with nonzero command");

  // Turn command stays within the clamp
  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(turn_cmd_o) <= 16'sd16384 && $signed(turn_cmd_o) >= -16'sd16384))
    else $error("turn command outside clamp");

  // The queue is never written while full nor read while empty
  a_queue_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && qstat.full) && !(pop && qstat.empty))
    else $error("queue overflow or underflow");

  // A held output beat does not change while the back end is frozen
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(turn_cmd_o) && $stable(stop_flag_o)))
    else $error("held beat changed");

endmodule

// File: sim/tb_line_follow_pid_steering_unit.sv
`timescale 1ns / 100ps

module tb_line_follow_pid_steering_unit;
  import lfps_pkg::*;

  // Accumulator range and turn scaling
  localparam longint ACC_HI     = 64'sh7F_FFFF_FFFF;
  localparam longint ACC_LO     = -ACC_HI - 1;
  localparam longint TURN_MUL   = 2621;
  localparam longint TURN_CLAMP = 16384;
  localparam int     LOST_OFS   = 16;

  // One steering command as seen on the output channel
  typedef struct packed {
    logic signed [CMD_W-1:0]    speed;
    logic signed [CMD_W-1:0]    turn;
    logic signed [OFFSET_W-1:0] offset;
    logic                       stop;
  } steer_cmd_t;

  // Steering predictor plus queue of commands still owed by the unit
  class steering_scoreboard;
    logic signed [GAIN_W-1:0] kp, ki, kd;
    logic signed [CMD_W-1:0]  speed;
    int         err1, err2;
    longint     acc;
    int         grp_pos;
    bit         grp_zero, stopped;
    steer_cmd_t expected_cmds[$];
    int         mismatches;

    function new();
      kp = GAIN_PROP_RST;
      ki = GAIN_INTEG_RST;
      kd = GAIN_DERIV_RST;
      speed = FORWARD_SPEED_RST;
      err1 = 0;
      err2 = 0;
      acc = 0;
      grp_pos = 0;
      grp_zero = 1'b1;
      stopped = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CMD_W-1:0] v);
      case (idx)
        CFG_GAIN_PROP:     kp = v;
        CFG_GAIN_INTEG:    ki = v;
        CFG_GAIN_DERIV:    kd = v;
        CFG_FORWARD_SPEED: speed = v;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    // Advance the controller by one accepted sensor beat
    function void note_sample(logic [SENSOR_W-1:0] w);
      int         e, kp_i, ki_i, kd_i;
      bit         found, stop_now;
      longint     d, sum, mag, t;
      steer_cmd_t c;
      e = LOST_OFS;
      found = 1'b0;
      stop_now = 1'b0;
      // lowest sensed bit wins: scan downward so the last hit sticks
      for (int k = SENSED_BITS - 1; k >= 0; k--) begin
        if (w[k]) begin
          e = (k - 6) * 2;
          found = 1'b1;
        end
      end
      if (found && $countones(w) == 3) e = e + 1;

      // incremental PID into the saturating accumulator
      kp_i = kp;
      ki_i = ki;
      kd_i = kd;
      d = longint'(kp_i) * (e - err1) + longint'(ki_i) * e
        + longint'(kd_i) * (e - 2 * err1 + err2);
      err2 = err1;
      err1 = e;
      if (kp_i == 0 && ki_i == 0 && kd_i == 0) begin
        acc = 0;
      end else begin
        sum = acc + d;
        if (sum > ACC_HI) sum = ACC_HI;
        if (sum < ACC_LO) sum = ACC_LO;
        acc = sum;
      end

      // turn magnitude, sign taken from the offset
      mag = (acc < 0) ? -acc : acc;
      t = (mag * TURN_MUL) >>> 16;
      if (t > TURN_CLAMP) t = TURN_CLAMP;

      // group bookkeeping for the lost-line stop
      if (w != '0) grp_zero = 1'b0;
      grp_pos++;
      if (grp_pos >= STOP_GROUP) begin
        if (grp_zero) begin
          stop_now = 1'b1;
          stopped = 1'b1;
        end
        grp_pos = 0;
        grp_zero = 1'b1;
      end

      c.offset = OFFSET_W'(e);
      if (stop_now) begin
        c.speed = '0;
        c.turn = '0;
        c.stop = 1'b1;
        expected_cmds.push_back(c);
      end else if (!stopped) begin
        c.speed = speed;
        c.turn = (e <= 0) ? CMD_W'(t) : CMD_W'(-t);
        c.stop = 1'b0;
        expected_cmds.push_back(c);
      end
    endfunction

    // Compare one output beat against the oldest owed command
    function void check_command(steer_cmd_t got);
      steer_cmd_t exp_c;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: command with none owed: speed %0d turn %0d ofs %0d stop %0b",
                   $realtime, got.speed, got.turn, got.offset, got.stop);
        return;
      end
      exp_c = expected_cmds.pop_front();
      if (got.speed !== exp_c.speed || got.turn !== exp_c.turn ||
          got.offset !== exp_c.offset || got.stop !== exp_c.stop) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: exp speed %0d turn %0d ofs %0d stop %0b, got %0d %0d %0d %0b",
                   $realtime, exp_c.speed, exp_c.turn, exp_c.offset, exp_c.stop,
                   got.speed, got.turn, got.offset, got.stop);
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CMD_W-1:0]           cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [SENSOR_W-1:0]        sensor_bits_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [CMD_W-1:0]    speed_cmd_o;
  logic signed [CMD_W-1:0]    turn_cmd_o;
  logic signed [OFFSET_W-1:0] line_offset_o;
  logic                       stop_flag_o;

  steering_scoreboard sb;
  bit                 quiet;
  int                 grp_slot;
  bit                 grp_blank;

  line_follow_pid_steering_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sensor_bits_i (sensor_bits_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .speed_cmd_o   (speed_cmd_o),
    .turn_cmd_o    (turn_cmd_o),
    .line_offset_o (line_offset_o),
    .stop_flag_o   (stop_flag_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_command('{speed_cmd_o, turn_cmd_o, line_offset_o, stop_flag_o});
  end

  // Receiver stall bursts, none once the run goes quiet
  initial begin
    int burst;
    burst = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        burst = 0;
        out_stall_i = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall_i = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 3);
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Sensor word with a spread of shapes so every offset shows up
  function automatic logic [SENSOR_W-1:0] pick_word();
    logic [SENSOR_W-1:0] w;
    int                  low;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = SENSOR_W'(1) << $urandom_range(0, 15);
      2, 3: begin
        // exactly three bits set
        low = $urandom_range(0, 13);
        w = SENSOR_W'(1) << low;
        while ($countones(w) < 3) w = w | (SENSOR_W'(1) << $urandom_range(low + 1, 15));
      end
      4, 5: w = SENSOR_W'($urandom_range(0, 65535)) << $urandom_range(0, 15);
      default: w = SENSOR_W'($urandom_range(0, 65535));
    endcase
    return w;
  endfunction

  // Drive one sensor beat; idle gap first now and then
  task automatic push_sample(input logic [SENSOR_W-1:0] w);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sensor_bits_i = w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(w);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Keep groups from going all-zero unless a stop is wanted
  task automatic send_word(input logic [SENSOR_W-1:0] w, input bit allow_stop);
    if (!allow_stop && grp_slot == STOP_GROUP - 1 && grp_blank && w == '0)
      w = SENSOR_W'($urandom_range(1, 65535));
    push_sample(w);
    if (w != '0) grp_blank = 1'b0;
    grp_slot++;
    if (grp_slot == STOP_GROUP) begin
      grp_slot = 0;
      grp_blank = 1'b1;
    end
  endtask

  task automatic run_batch(input int n);
    repeat (n) send_word(pick_word(), 1'b0);
  endtask

  // Drain all owed commands, then let the pipeline empty
  task automatic settle();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CMD_W-1:0] v);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = v;
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_setting(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                               input logic [GAIN_W-1:0] dv, input logic [CMD_W-1:0] s);
    settle();
    write_reg(CFG_GAIN_PROP, p);
    write_reg(CFG_GAIN_INTEG, i);
    write_reg(CFG_GAIN_DERIV, dv);
    write_reg(CFG_FORWARD_SPEED, s);
  endtask

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main sequence
  initial begin
    logic [SENSOR_W-1:0] directed_words[16];
    sb = new();
    quiet = 1'b0;
    grp_slot = 0;
    grp_blank = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_GAIN_PROP;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sensor_bits_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // lost line, edge bits, three-bit words, the unsensed top bit alone
    directed_words = '{16'h0000, 16'h0001, 16'h0007, 16'h4000,
                       16'h8000, 16'hC000, 16'h8003, 16'hFFFF,
                       16'h0040, 16'h01C0, 16'h7000, 16'h0000,
                       16'h0000, 16'h0000, 16'h0000, 16'h2000};
    foreach (directed_words[j]) send_word(directed_words[j], 1'b0);
    run_batch(300);

    // gain and speed extremes
    apply_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    run_batch(250);
    apply_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    run_batch(250);

    // all gains zero holds the accumulator at zero
    apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_batch(150);

    // small gains keep the turn out of its clamp
    apply_setting(GAIN_W'($urandom_range(0, 1024) - 512), GAIN_W'($urandom_range(0, 64)),
                  GAIN_W'($urandom_range(0, 256) - 128), CMD_W'($urandom_range(0, 65535)));
    run_batch(200);
    repeat (2) begin
      apply_setting(GAIN_W'($urandom_range(0, 65535)), GAIN_W'($urandom_range(0, 65535)),
                    GAIN_W'($urandom_range(0, 65535)), CMD_W'($urandom_range(0, 65535)));
      run_batch(200);
    end
    apply_setting(16'h0000, 16'h0000, 16'h0001, CMD_W'($urandom_range(0, 65535)));
    run_batch(100);

    // quiet tail: trigger the stop, then only all-zero groups answer
    apply_setting(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST, FORWARD_SPEED_RST);
    quiet = 1'b1;
    run_batch(32);
    for (int g = 0; g < 30; g++) begin
      if (g == 0 || $urandom_range(0, 9) < 6) begin
        repeat (STOP_GROUP) send_word('0, 1'b1);
      end else begin
        repeat (STOP_GROUP) send_word(pick_word(), 1'b1);
      end
    end
    in_valid_i = 1'b0;

    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/lfps_pkg.sv
rtl/lfps_front.sv
rtl/lfps_queue.sv
rtl/lfps_back.sv
rtl/line_follow_pid_steering_unit.sv
sim/tb_line_follow_pid_steering_unit.sv
